// ===== rtl/assert_macros.svh =====
// assertion macros for the rtl files, included by the k-th root top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// property checked at every clock edge outside reset
`define ASSERT_CLK(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// implication checked at every clock edge outside reset
`define ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

`else

`define ASSERT_CLK(label, clk, rstn, prop, msg)
`define ASSERT_IMPL(label, clk, rstn, ante, cons, msg)

`endif

`endif

// ===== rtl/kthr_pkg.sv =====
// shared types and constants for the k-th root bisection block
package kthr_pkg;

    // width of one partial-product operand half
    localparam int PP_BITS   = 32;
    // operand and full product widths of the shared multiplier
    localparam int OPND_BITS = 2 * PP_BITS;
    localparam int PROD_BITS = 2 * OPND_BITS;
    // width of the tolerance register
    localparam int TOL_BITS  = 33;

    typedef struct packed {
        logic done;
        logic sat;
    } mul_status_t;

endpackage

// ===== rtl/kthr_fxmul.sv =====
// iterative fixed-point multiplier built on one 32x32 partial-product multiplier
module kthr_fxmul #(
    parameter int FRAC_BITS = 32,
    parameter int WORD_BITS = 64
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           start,
    input  logic [kthr_pkg::OPND_BITS-1:0] a,
    input  logic [kthr_pkg::OPND_BITS-1:0] b,
    output logic [WORD_BITS-1:0]           prod,
    output kthr_pkg::mul_status_t          status
);
    import kthr_pkg::*;

    logic [OPND_BITS-1:0] a_reg;
    logic [OPND_BITS-1:0] b_reg;
    logic [2:0]           step_reg;
    logic [OPND_BITS-1:0] pp_reg;
    logic [1:0]           pp_shift_reg;
    logic                 pp_valid_reg;
    logic                 pp_last_reg;
    logic                 done_reg;
    logic [PROD_BITS-1:0] acc_reg;

    logic [PP_BITS-1:0]   a_half;
    logic [PP_BITS-1:0]   b_half;
    logic [OPND_BITS-1:0] pp_next;
    logic [PROD_BITS-1:0] pp_aligned;

    always_comb begin
        a_half  = step_reg[0] ? a_reg[OPND_BITS-1:PP_BITS] : a_reg[PP_BITS-1:0];
        b_half  = step_reg[1] ? b_reg[OPND_BITS-1:PP_BITS] : b_reg[PP_BITS-1:0];
        pp_next = {{PP_BITS{1'b0}}, a_half} * {{PP_BITS{1'b0}}, b_half};
    end

    // place the partial product at its weight
    always_comb begin
        unique case (pp_shift_reg)
            2'd1: pp_aligned = {{PP_BITS{1'b0}}, pp_reg, {PP_BITS{1'b0}}};
            2'd2: pp_aligned = {pp_reg, {OPND_BITS{1'b0}}};
            default: pp_aligned = {{OPND_BITS{1'b0}}, pp_reg};
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg     <= 3'd4;
            pp_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end else begin
            done_reg     <= pp_valid_reg && pp_last_reg;
            pp_valid_reg <= !step_reg[2];
            if (start) begin
                step_reg <= 3'd0;
            end else if (!step_reg[2]) begin
                step_reg <= step_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            a_reg <= a;
            b_reg <= b;
        end
        pp_reg       <= pp_next;
        pp_shift_reg <= {1'b0, step_reg[0]} + {1'b0, step_reg[1]};
        pp_last_reg  <= (step_reg[1:0] == 2'b11);
        if (start) begin
            acc_reg <= '0;
        end else if (pp_valid_reg) begin
            acc_reg <= acc_reg + pp_aligned;
        end
    end

    assign prod        = acc_reg[FRAC_BITS+WORD_BITS-1:FRAC_BITS];
    assign status.sat  = |acc_reg[PROD_BITS-1:FRAC_BITS+WORD_BITS];
    assign status.done = done_reg;

endmodule

// ===== rtl/kth_root_bisection.sv =====
// k-th root of an unsigned fixed-point radicand by bisection, top level
//
//  channel  | dir | handshake          | payload
//  ---------+-----+--------------------+---------------------------------
//  s_       | in  | s_tvalid/s_tready  | radicand [63:0], degree [68:64]
//  m_       | out | m_tvalid/m_tready  | root [63:0]
//  cfg_     | in  | cfg_we             | tolerance [32:0]
//
// one request runs up to about 64 bisection steps; each step makes up to k passes
// through the shared multiplier, each pass a launch state and then a wait for its four
// 32x32 partial products; a saturated power skips the decide state
// synchronous active-low reset; tolerance resets to 1, no clearing pass
// s_tready is high only while the sequencer is idle; a finished root waits
// in the output register, and a later root waits for it to be taken
module kth_root_bisection #(
    parameter int FRAC_BITS  = 32,
    parameter int INT_BITS   = 32,
    parameter int MAX_DEGREE = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // radicand [63:0], degree [68:64], zero [71:69]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // root [63:0]
    input  logic        cfg_we,
    input  logic [32:0] cfg_wdata  // tolerance [32:0]
);
    import kthr_pkg::*;

    `include "assert_macros.svh"

    // word width of the fixed-point format
    localparam int W  = (INT_BITS + FRAC_BITS >= 64) ? 64 : INT_BITS + FRAC_BITS;
    // width of the degree counter
    localparam int KW = $clog2(MAX_DEGREE + 1);
    // width used for compares against the tolerance
    localparam int CW = (W > TOL_BITS) ? W : TOL_BITS;
    localparam logic [W-1:0] ONE_FX = {{(W-1){1'b0}}, 1'b1} << FRAC_BITS;

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_CHECK  = 8'b0000_0010,
        S_MID    = 8'b0000_0100,
        S_MUL    = 8'b0000_1000,
        S_WAIT   = 8'b0001_0000,
        S_EVAL   = 8'b0010_0000,
        S_DECIDE = 8'b0100_0000,
        S_OUT    = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    logic [TOL_BITS-1:0] tol_reg;
    logic [W-1:0]        n_reg;
    logic [KW-1:0]       k_reg;
    logic [KW-1:0]       i_reg;
    logic [W-1:0]        lo_reg;
    logic [W-1:0]        hi_reg;
    logic [W-1:0]        t_reg;
    logic [W-1:0]        half_reg;
    logic [W-1:0]        p_reg;
    logic                sat_reg;
    logic [W-1:0]        d_reg;
    logic                p_lt_reg;
    logic                m_tvalid_reg;
    logic [63:0]         m_tdata_reg;

    logic [TOL_BITS-1:0] tol_eff;
    logic [CW-1:0]       tol_cmp;
    logic [W-1:0]        width_diff;
    logic                keep_going;
    logic                p_ge_n;
    logic [W-1:0]        resid;
    logic [31:0]         deg_ext;
    logic [31:0]         deg_clamp;
    logic                accept;
    logic                out_free;
    logic                mul_start;
    logic [W-1:0]        mul_prod;
    mul_status_t         mul_stat;

    // zero tolerance behaves as one lsb so the interval always shrinks
    assign tol_eff = (tol_reg == '0) ? {{(TOL_BITS-1){1'b0}}, 1'b1} : tol_reg;
    assign tol_cmp = CW'(tol_eff);

    // interval test: continue while hi > lo and hi - lo > tolerance
    assign width_diff = hi_reg - lo_reg;
    assign keep_going = (hi_reg > lo_reg) && (CW'(width_diff) > tol_cmp);

    // residual magnitude of the power against the radicand
    assign p_ge_n = (p_reg >= n_reg);
    assign resid  = p_ge_n ? (p_reg - n_reg) : (n_reg - p_reg);

    // degrees above the supported maximum are clamped
    assign deg_ext   = {27'd0, s_tdata[68:64]};
    assign deg_clamp = (deg_ext > 32'(MAX_DEGREE)) ? 32'(MAX_DEGREE) : deg_ext;

    assign s_tready  = (state_reg == S_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign mul_start = (state_reg == S_MUL);

    kthr_fxmul #(
        .FRAC_BITS (FRAC_BITS),
        .WORD_BITS (W)
    ) u_fxmul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .a       (OPND_BITS'(p_reg)),
        .b       (OPND_BITS'(t_reg)),
        .prod    (mul_prod),
        .status  (mul_stat)
    );

    // sequencer
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK: begin
                state_next = keep_going ? S_MID : S_OUT;
            end
            S_MID: begin
                state_next = (k_reg == '0) ? S_EVAL : S_MUL;
            end
            S_MUL: begin
                state_next = S_WAIT;
            end
            S_WAIT: begin
                if (mul_stat.done) begin
                    if (mul_stat.sat || (KW'(i_reg + 1'b1) == k_reg)) begin
                        state_next = S_EVAL;
                    end else begin
                        state_next = S_MUL;
                    end
                end
            end
            S_EVAL: begin
                state_next = sat_reg ? S_CHECK : S_DECIDE;
            end
            S_DECIDE: begin
                // within tolerance returns the probe at once
                state_next = (CW'(d_reg) <= tol_cmp) ? S_OUT : S_CHECK;
            end
            S_OUT: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            tol_reg      <= {{(TOL_BITS-1){1'b0}}, 1'b1};
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_we) begin
                tol_reg <= cfg_wdata;
            end
            if ((state_reg == S_OUT) && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    n_reg  <= s_tdata[W-1:0];
                    k_reg  <= KW'(deg_clamp);
                    lo_reg <= ONE_FX;
                    hi_reg <= s_tdata[W-1:0];
                    // no probe yet: a narrow start returns zero
                    t_reg  <= '0;
                end
            end
            S_CHECK: begin
                half_reg <= width_diff >> 1;
            end
            S_MID: begin
                t_reg   <= lo_reg + half_reg;
                p_reg   <= ONE_FX;
                i_reg   <= '0;
                sat_reg <= 1'b0;
            end
            S_WAIT: begin
                if (mul_stat.done) begin
                    p_reg   <= mul_prod;
                    sat_reg <= mul_stat.sat;
                    i_reg   <= KW'(i_reg + 1'b1);
                end
            end
            S_EVAL: begin
                d_reg    <= resid;
                p_lt_reg <= !p_ge_n;
                // a saturated power counts as too large
                if (sat_reg) begin
                    hi_reg <= t_reg;
                end
            end
            S_DECIDE: begin
                if (CW'(d_reg) > tol_cmp) begin
                    if (p_lt_reg) begin
                        lo_reg <= t_reg;
                    end else begin
                        hi_reg <= t_reg;
                    end
                end
            end
            S_OUT: begin
                if (out_free) begin
                    m_tdata_reg <= 64'(t_reg);
                end
            end
            default: begin
            end
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // a request is taken only once before the search runs
    `ASSERT_CLK(a_one_accept, aclk, aresetn, accept |=> !s_tready, "second request taken early")
    // multiplier results arrive only while the sequencer waits for them
    `ASSERT_IMPL(a_done_in_wait, aclk, aresetn, mul_stat.done, state_reg == S_WAIT,
        "multiplier result outside wait")
    // the power loop never runs past the degree
    `ASSERT_IMPL(a_pow_bound, aclk, aresetn, state_reg == S_WAIT, i_reg < k_reg,
        "power loop overran degree")

endmodule

// ===== tb/root_checker.sv =====
// stream monitor that predicts and checks k-th root results
`timescale 1ns / 1ps

module root_checker #(
    parameter int FRAC_BITS  = 32,
    parameter int MAX_DEGREE = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic [71:0]                   s_tdata,   // radicand [63:0], degree [68:64], zero [71:69]
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [63:0]                   m_tdata,   // root [63:0]
    input  logic                          cfg_we,
    input  logic [kthr_pkg::TOL_BITS-1:0] cfg_wdata, // tolerance [32:0]
    output int                            fail_count,
    output int                            pending
);
    import kthr_pkg::*;

    localparam logic [63:0] ONE = 64'd1 << FRAC_BITS;

    logic [TOL_BITS-1:0] tol_reg;
    logic [63:0]         roots_due[$];
    logic [63:0]         want_root;

    // bisection over [1.0, radicand], power by repeated truncating multiplies
    function automatic logic [63:0] bisect_root(input logic [63:0] n, input logic [4:0] deg,
                                                input logic [TOL_BITS-1:0] tol_in);
        logic [63:0]  lo, hi, t, p, d, tol;
        logic [127:0] prod;
        logic         sat, hit;
        int           k, i;
        tol = 64'(tol_in);
        if (tol == 0)
            tol = 1;
        k = int'(deg);
        if (k > MAX_DEGREE)
            k = MAX_DEGREE;
        lo  = ONE;
        hi  = n;
        t   = 0;
        hit = 1'b0;
        while (!hit && hi > lo && hi - lo > tol) begin
            p   = ONE;
            sat = 1'b0;
            t   = lo + ((hi - lo) >> 1);
            for (i = 0; i < k && !sat; i++) begin
                prod = {64'd0, p} * {64'd0, t};
                if ((prod >> (64 + FRAC_BITS)) != 0) begin
                    sat = 1'b1;
                    p   = '1;
                end else begin
                    p = 64'(prod >> FRAC_BITS);
                end
            end
            d = (p >= n) ? p - n : n - p;
            // saturated power always counts as too large
            if (!sat && d <= tol)
                hit = 1'b1;
            else if (!sat && p < n)
                lo = t;
            else
                hi = t;
        end
        return t;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            tol_reg <= 1;
            roots_due.delete();
            pending <= 0;
        end else begin
            if (cfg_we)
                tol_reg <= cfg_wdata;
            if (s_tvalid && s_tready)
                roots_due.push_back(bisect_root(s_tdata[63:0], s_tdata[68:64], tol_reg));
            if (m_tvalid && m_tready) begin
                if (roots_due.size() == 0) begin
                    if (fail_count < 10)
                        $display("root %h with no request outstanding", m_tdata);
                    fail_count++;
                end else begin
                    want_root = roots_due.pop_front();
                    if (m_tdata !== want_root) begin
                        if (fail_count < 10)
                            $display("root mismatch: expected %h, got %h", want_root, m_tdata);
                        fail_count++;
                    end
                end
            end
            pending <= roots_due.size();
        end
    end

endmodule

// ===== tb/tb_kth_root_bisection.sv =====
// stimulus and verdict for the k-th root bisection block
`timescale 1ns / 1ps

module tb_kth_root_bisection;
    import kthr_pkg::*;

    localparam logic [63:0] ONE        = 64'h1_0000_0000;
    localparam logic [63:0] MAX_WORD   = '1;
    localparam int          QUIET_LIMIT = 100000;  // many times the slowest request
    localparam int          PHASE_LEN  = 104;

    logic                aclk;
    logic                aresetn   = 1'b0;
    logic                s_tvalid  = 1'b0;
    logic                s_tready;
    logic [71:0]         s_tdata   = '0;   // radicand [63:0], degree [68:64], zero [71:69]
    logic                m_tvalid;
    logic                m_tready  = 1'b0;
    logic [63:0]         m_tdata;          // root [63:0]
    logic                cfg_we    = 1'b0;
    logic [TOL_BITS-1:0] cfg_wdata = '0;   // tolerance [32:0]

    // random idling on both channels, switched off for one whole phase
    logic                idle_on   = 1'b1;
    // tolerance last written, steers radicands toward the narrow-start edge
    logic [TOL_BITS-1:0] tol_now   = 1;
    int                  fail_count;
    int                  pending;
    int unsigned         quiet_cycles = 0;

    kth_root_bisection #(
        .FRAC_BITS (32),
        .INT_BITS  (32),
        .MAX_DEGREE(16)
    ) DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata)
    );

    root_checker #(
        .FRAC_BITS (32),
        .MAX_DEGREE(16)
    ) u_checker (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .fail_count(fail_count),
        .pending   (pending)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // result side back-pressure, stalling about 8 percent of the time
    always @(posedge aclk) begin
        m_tready <= aresetn && (!idle_on || $urandom_range(99) >= 8);
    end

    // watchdog: too long without any accepted request or result
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // present one request and hold it until accepted; tvalid stays high after
    task automatic send_request(input logic [63:0] radicand, input logic [4:0] degree);
        while (idle_on && $urandom_range(99) < 8) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tdata  <= {3'b000, degree, radicand};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
    endtask

    // tolerance changes only with the block drained
    task automatic set_tolerance(input logic [TOL_BITS-1:0] value);
        @(posedge aclk);
        wait (pending == 0);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        tol_now    = value;
        @(posedge aclk);
        cfg_we    <= 1'b0;
    endtask

    function automatic logic [63:0] random_radicand();
        logic [63:0] eff_tol;
        int unsigned pick;
        eff_tol = (tol_now == 0) ? 64'd1 : 64'(tol_now);
        pick    = $urandom_range(99);
        if (pick < 8)
            return ONE + eff_tol - 64'd1 + 64'($urandom_range(0, 2));   // narrow-start edge
        else if (pick < 14)
            return {32'd0, 32'($urandom)};                                // below 1.0
        else if (pick < 50)
            return {24'd0, 8'($urandom_range(0, 255)), 32'($urandom)};
        else if (pick < 75)
            return {16'd0, 16'($urandom), 32'($urandom)};
        else
            return {32'($urandom), 32'($urandom)};
    endfunction

    // mostly low degrees, which keep each request short
    function automatic logic [4:0] random_degree();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 70)
            return 5'($urandom_range(2, 6));
        else if (pick < 92)
            return 5'($urandom_range(7, 16));
        else
            return 5'($urandom_range(0, 31));
    endfunction

    task automatic run_phase(input int count);
        repeat (count) send_request(random_radicand(), random_degree());
        s_tvalid <= 1'b0;
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed requests at the reset tolerance
        send_request(64'd0, 5'd2);                    // zero radicand, narrow start
        send_request(64'h0000_0000_FFFF_FFFF, 5'd3);  // just below 1.0
        send_request(ONE, 5'd2);                      // exactly 1.0
        send_request(ONE + 64'd1, 5'd2);              // 1.0 plus tolerance
        send_request(ONE + 64'd2, 5'd2);              // first case that probes
        send_request(64'd4 << 32, 5'd2);
        send_request(64'd9 << 32, 5'd2);
        send_request(64'd27 << 32, 5'd3);
        send_request(64'd65536 << 32, 5'd16);         // root of 2 exactly
        send_request(64'd2 << 32, 5'd2);
        send_request(64'd2 << 32, 5'd8);
        send_request(64'h0000_03E8_8000_0000, 5'd3);  // 1000.5
        send_request(64'd10 << 32, 5'd0);             // power fixed at 1.0
        send_request(64'd10 << 32, 5'd1);             // power is the probe itself
        send_request(64'd100 << 32, 5'd17);           // degree clamped
        send_request(64'h8000_0000_0000_0000, 5'd5);
        send_request(MAX_WORD, 5'd2);
        send_request(MAX_WORD, 5'd16);                // power overflow
        send_request(MAX_WORD, 5'd31);
        send_request(ONE + 64'd3, 5'd31);
        s_tvalid <= 1'b0;

        // zero tolerance acts as one
        set_tolerance('0);
        run_phase(PHASE_LEN);

        // tolerance of 1.0, the widest that this bench writes
        set_tolerance(33'h1_0000_0000);
        run_phase(PHASE_LEN);

        // small tolerance, no idling on either channel
        set_tolerance(33'($urandom_range(1, 1000)));
        idle_on <= 1'b0;
        run_phase(PHASE_LEN);
        idle_on <= 1'b1;

        set_tolerance({1'b0, 32'($urandom)} + 33'd1);
        run_phase(PHASE_LEN);

        set_tolerance(33'd1);
        run_phase(PHASE_LEN);

        // drain, then let the block settle
        @(posedge aclk);
        wait (pending == 0);
        repeat (50) @(posedge aclk);
        if (fail_count == 0 && pending == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
